FILE: rtl/core/wavelet_detail_coeff_prune_core_macros.svh
// assertion macros for the wavelet detail pruning core
`ifndef WAVELET_DETAIL_COEFF_PRUNE_CORE_MACROS_SVH
`define WAVELET_DETAIL_COEFF_PRUNE_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define WDCP_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define WDCP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/wdcp_pkg.sv
// shared types, constants and helpers for the wavelet detail pruning core
`default_nettype none

package wdcp_pkg;

  localparam int COEFF_BITS = 16;
  localparam int LOWRES_BITS = 16;
  // compare width: holds a sum of two coefficients and a 16-bit threshold, signed
  localparam int CMP_W = (COEFF_BITS + 2 > 18) ? COEFF_BITS + 2 : 18;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

  typedef logic signed [COEFF_BITS-1:0] coeff_t;
  typedef logic signed [LOWRES_BITS-1:0] lowres_t;
  typedef logic signed [CMP_W-1:0] cmp_t;
  typedef logic [1:0] band_t;

  localparam band_t BAND_PASS = 2'd0;
  localparam band_t BAND_LH = 2'd1;
  localparam band_t BAND_HH = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_RATIO = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LH_LIMIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HH_LIMIT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOWRES_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PAIR_LIMIT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SNAP_THRESHOLD = 3'd5;

  localparam logic [15:0] SNAP_RESET = 16'hFFFF;

  // band rule offsets
  localparam cmp_t LH_FIRST_OFF = cmp_t'(2);
  localparam cmp_t HH_FIRST_OFF = cmp_t'(1);
  localparam cmp_t HH_LOW_OFF = cmp_t'(1);
  localparam cmp_t LH_SNAP_OFF = cmp_t'(4);
  localparam cmp_t HH_SNAP_OFF = cmp_t'(5);
  localparam cmp_t SNAP_VALUE = cmp_t'(7);

  typedef struct packed {
    logic [7:0] ratio;
    logic [7:0] lh_limit;
    logic [7:0] hh_limit;
    logic [7:0] lowres_limit;
    logic [7:0] pair_limit;
    logic [15:0] snap_threshold;
  } cfg_t;

  typedef struct packed {
    coeff_t coeff;
    logic last;
  } result_t;

  function automatic cmp_t abs_cmp(cmp_t v);
    return v[CMP_W-1] ? -v : v;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/wdcp_prune.sv
// decision logic for one coefficient given its left and right neighbors
`default_nettype none

module wdcp_prune import wdcp_pkg::*; (
  input  cfg_t    cfg,
  input  band_t   band,
  input  coeff_t  lf,
  input  coeff_t  c,
  input  coeff_t  rt,
  input  lowres_t lr,
  output coeff_t  lf_out,
  output coeff_t  c_out,
  output coeff_t  rt_out
);

  logic is_lh, is_hh, active, skip, cand, fin;
  logic zero_c, zero_l, zero_r;
  cmp_t cc, cl, cr;
  cmp_t ratio, pair, lim, first, low_bound, snap_off, thr;
  cmp_t mc, mlf, mrt, mlr, msum_l, msum_r;
  cmp_t c1, mc1, mlf1, mrt1, c2;

  always_comb begin
    is_lh = (band == BAND_LH);
    is_hh = (band == BAND_HH);
    active = is_lh || is_hh;

    cc = cmp_t'(c);
    cl = cmp_t'(lf);
    cr = cmp_t'(rt);

    ratio = cmp_t'(cfg.ratio);
    pair = cmp_t'(cfg.pair_limit);
    thr = cmp_t'(cfg.snap_threshold);
    lim = is_hh ? cmp_t'(cfg.hh_limit) : cmp_t'(cfg.lh_limit);
    first = lim + (is_hh ? HH_FIRST_OFF : LH_FIRST_OFF);
    low_bound = cmp_t'(cfg.lowres_limit) + (is_hh ? HH_LOW_OFF : cmp_t'(0));
    snap_off = is_hh ? HH_SNAP_OFF : LH_SNAP_OFF;

    mc = abs_cmp(cc);
    mlf = abs_cmp(cl);
    mrt = abs_cmp(cr);
    mlr = abs_cmp(cmp_t'(lr));
    msum_l = abs_cmp(cc + cl);
    msum_r = abs_cmp(cc + cr);
  end

  // first pass: low-res test, then cancelling pair with left, then with right
  always_comb begin
    skip = is_hh && (mc < ratio);
    cand = active && !skip && (mc >= ratio) && (mc < first);
    zero_c = 1'b0;
    zero_l = 1'b0;
    zero_r = 1'b0;
    if (cand) begin
      priority if (mlr < low_bound) begin
        zero_c = 1'b1;
      end else if ((msum_l < pair) && (mrt < pair)) begin
        zero_c = 1'b1;
        zero_l = 1'b1;
      end else if ((msum_r < pair) && (mlf < pair)) begin
        zero_c = 1'b1;
        zero_r = 1'b1;
      end
    end
  end

  // second pass works on the values left by the first
  always_comb begin
    c1 = zero_c ? '0 : cc;
    mc1 = zero_c ? '0 : mc;
    mlf1 = zero_l ? '0 : mlf;
    mrt1 = zero_r ? '0 : mrt;
    fin = active && !skip && (is_hh || (mc1 >= ratio)) && (mc1 < lim) &&
          (((mlf1 < ratio) && (mrt1 < ratio)) || ((mc1 + snap_off) < lim));
    c2 = c1;
    if (fin) begin
      if (is_hh) begin
        priority if (c1 >= thr) begin
          c2 = SNAP_VALUE;
        end else if (c1 <= -thr) begin
          c2 = -SNAP_VALUE;
        end else begin
          c2 = '0;
        end
      end else begin
        c2 = '0;
      end
    end
  end

  assign c_out = coeff_t'(c2);
  assign lf_out = zero_l ? '0 : lf;
  assign rt_out = zero_r ? '0 : rt;

endmodule

`default_nettype wire

FILE: rtl/core/wavelet_detail_coeff_prune_core.sv
// Wavelet detail coefficient pruning core. Coefficients stream in raster order with
// their low-res value and band tag; each one is decided when its right neighbor
// arrives, may still be zeroed by that neighbor's decision, and is queued when the
// beat after that neighbor is taken. A beat with last set flushes the window on a
// later cycle, the first one that finds two free output queue entries, sending out
// the remaining one or two values with last_out on the final one. Throughput is one
// coefficient per clock while input is not stalled. Results go through a 4-entry
// output queue, and input stalls only when that queue is full or the flush is pending.
// The configuration port is always ready; the user must write it only while the core is idle (the core does not check).
`default_nettype none

module wavelet_detail_coeff_prune_core import wdcp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  coeff_t               coeff,
  input  lowres_t              lowres,
  input  band_t                band,
  input  logic                 last,
  output logic                 out_valid,
  input  logic                 out_stall,
  output coeff_t               coeff_out,
  output logic                 last_out
);

  cfg_t cfg;

  // window: prev is decided but may still be zeroed by cur's decision, cur waits for its right neighbor
  coeff_t  prev_coeff;
  logic    prev_valid;
  coeff_t  cur_coeff;
  lowres_t cur_lowres;
  band_t   cur_band;
  logic    cur_valid;
  logic    flush_pending;

  result_t fifo_mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr, rd_ptr, wr_ptr_b;
  logic [FIFO_CNT_W-1:0] count, count_next;

  logic in_fire, flush_fire, pop;
  logic [1:0] push_cnt;
  result_t push_a, push_b;

  coeff_t p_lf, p_rt, n_lf, n_c, n_rt;
  band_t  p_band;

  logic last_fire, window_clear, queue_ok;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ratio <= '0;
      cfg.lh_limit <= '0;
      cfg.hh_limit <= '0;
      cfg.lowres_limit <= '0;
      cfg.pair_limit <= '0;
      cfg.snap_threshold <= SNAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_RATIO:          cfg.ratio <= cfg_data[7:0];
        CFG_LH_LIMIT:       cfg.lh_limit <= cfg_data[7:0];
        CFG_HH_LIMIT:       cfg.hh_limit <= cfg_data[7:0];
        CFG_LOWRES_LIMIT:   cfg.lowres_limit <= cfg_data[7:0];
        CFG_PAIR_LIMIT:     cfg.pair_limit <= cfg_data[7:0];
        CFG_SNAP_THRESHOLD: cfg.snap_threshold <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign in_stall = flush_pending || (count == FIFO_CNT_W'(FIFO_DEPTH));
  assign in_fire = in_valid && !in_stall;
  assign flush_fire = flush_pending && (count <= FIFO_CNT_W'(FIFO_DEPTH - 2));
  assign out_valid = (count != '0);
  assign pop = out_valid && !out_stall;

  // one decision unit, shared by the normal beat and the flush
  assign p_lf = prev_valid ? prev_coeff : '0;
  assign p_rt = flush_pending ? '0 : coeff;
  assign p_band = cur_valid ? cur_band : BAND_PASS;

  wdcp_prune u_prune (
    .cfg    (cfg),
    .band   (p_band),
    .lf     (p_lf),
    .c      (cur_coeff),
    .rt     (p_rt),
    .lr     (cur_lowres),
    .lf_out (n_lf),
    .c_out  (n_c),
    .rt_out (n_rt)
  );

  always_comb begin
    push_cnt = 2'd0;
    push_a = '0;
    push_b = '0;
    if (flush_fire) begin
      if (prev_valid) begin
        push_a = '{coeff: n_lf, last: 1'b0};
        push_b = '{coeff: n_c, last: 1'b1};
        push_cnt = 2'd2;
      end else begin
        push_a = '{coeff: n_c, last: 1'b1};
        push_cnt = 2'd1;
      end
    end else if (in_fire && prev_valid) begin
      push_a = '{coeff: n_lf, last: 1'b0};
      push_cnt = 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_valid <= 1'b0;
      cur_valid <= 1'b0;
      flush_pending <= 1'b0;
    end else if (flush_fire) begin
      prev_valid <= 1'b0;
      cur_valid <= 1'b0;
      flush_pending <= 1'b0;
    end else if (in_fire) begin
      prev_valid <= cur_valid;
      cur_valid <= 1'b1;
      flush_pending <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      prev_coeff <= cur_valid ? n_c : '0;
      cur_coeff <= n_rt;
      cur_lowres <= lowres;
      cur_band <= band;
    end
  end

  // output queue, up to two beats written per cycle
  assign wr_ptr_b = wr_ptr + FIFO_PTR_W'(1);
  assign count_next = count + FIFO_CNT_W'(push_cnt) - FIFO_CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      fifo_mem[wr_ptr] <= push_a;
    end
    if (push_cnt == 2'd2) begin
      fifo_mem[wr_ptr_b] <= push_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      wr_ptr <= wr_ptr + FIFO_PTR_W'(push_cnt);
      rd_ptr <= rd_ptr + FIFO_PTR_W'(pop);
      count <= count_next;
    end
  end

  assign coeff_out = fifo_mem[rd_ptr].coeff;
  assign last_out = fifo_mem[rd_ptr].last;

  assign last_fire = in_fire && last;
  assign window_clear = !cur_valid && !prev_valid && !flush_pending;
  assign queue_ok = (count_next <= FIFO_CNT_W'(FIFO_DEPTH));

`include "wavelet_detail_coeff_prune_core_macros.svh"

  `WDCP_ASSERT_SAME(a_flush_has_item, clk, rst, flush_pending, cur_valid, "empty window in flush")
  `WDCP_ASSERT_NEXT(a_last_starts_flush, clk, rst, last_fire, flush_pending, "flush not started")
  `WDCP_ASSERT_NEXT(a_flush_clears, clk, rst, flush_fire, window_clear, "flush left window")
  `WDCP_ASSERT_SAME(a_queue_bounds, clk, rst, 1'b1, queue_ok, "output queue overflow")

endmodule

`default_nettype wire
